/* design/csm_pkg.sv */
// Shared types, constants and decode functions for the CSI subcarrier magnitude block.
package csm_pkg;

	localparam int CARRIERS  = 64;
	localparam int FRAC_BITS = 8;

	localparam int IDX_W  = 6;
	localparam int MASK_W = 64;
	localparam int CHAR_W = 64;
	localparam int MAG_W  = 24;
	localparam int PART_W = 16;
	localparam int ABS_W  = 16;
	localparam int SUM_W  = 2 * ABS_W;
	localparam int RAD_W  = SUM_W + 2 * FRAC_BITS;
	localparam int ROOT_W = RAD_W / 2;
	localparam int STEP_W = $clog2(ROOT_W + 1);
	localparam int SAT_W  = ((ROOT_W > MAG_W) ? ROOT_W : MAG_W) + 1;

	localparam logic [MASK_W-1:0] MASK_RESET   = 64'hFFFF_FFF0_1FFF_FFFE;
	localparam logic [MASK_W-1:0] CARRIER_MASK = (64'd1 << CARRIERS) - 64'd1;
	localparam logic [IDX_W-1:0]  LAST_IDX     = IDX_W'(CARRIERS - 1);
	localparam logic [MAG_W-1:0]  MAG_MAX      = '1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SQ_RE,
		ST_SQ_IM,
		ST_LOAD,
		ST_ROOT,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic             start;
		logic [RAD_W-1:0] radicand;
	} root_req_t;

	typedef struct packed {
		logic              done;
		logic [ROOT_W-1:0] root;
	} root_rsp_t;

	// Returns {valid, nibble} for one ASCII character.
	function automatic logic [4:0] hex_nibble(input logic [7:0] c);
		logic [4:0] r;
		r = 5'd0;
		if (c >= 8'h30 && c <= 8'h39) begin
			r = {1'b1, 4'(c - 8'h30)};
		end else if (c >= 8'h61 && c <= 8'h66) begin
			r = {1'b1, 4'(c - 8'h57)};
		end else if (c >= 8'h41 && c <= 8'h46) begin
			r = {1'b1, 4'(c - 8'h37)};
		end
		return r;
	endfunction

	// Decodes four characters with swapped byte pairs; returns {valid, value}.
	function automatic logic [PART_W:0] part_decode(input logic [31:0] chars);
		logic [4:0] n0;
		logic [4:0] n1;
		logic [4:0] n2;
		logic [4:0] n3;
		n0 = hex_nibble(chars[7:0]);
		n1 = hex_nibble(chars[15:8]);
		n2 = hex_nibble(chars[23:16]);
		n3 = hex_nibble(chars[31:24]);
		return {n0[4] & n1[4] & n2[4] & n3[4], n2[3:0], n3[3:0], n0[3:0], n1[3:0]};
	endfunction

	// Magnitude of a two's complement value; the most negative value maps to 2^15.
	function automatic logic [ABS_W-1:0] abs_part(input logic [PART_W-1:0] v);
		return v[PART_W-1] ? ABS_W'(~v + 1'b1) : ABS_W'(v);
	endfunction

endpackage

/* design/csi_subcarrier_magnitude.sv */
// Top level: CSI subcarrier decode, mask selection and magnitude sequencer.
//
// Input channel: hex_chars with in_valid/in_stall. One transaction is one
// subcarrier; subcarrier indexes count up from 0 and wrap after CARRIERS-1,
// which also restarts the feature index.
// Output channel: magnitude, feature_index, subcarrier_index, bad_digit and
// last_feature with out_valid/out_stall. Only subcarriers whose keep_mask bit
// is set produce a transaction; others are absorbed in the accepting cycle.
// Configuration: keep_mask with cfg_valid/cfg_ready, taken while idle.
// A kept subcarrier with valid digits passes through the shared 16x16
// squarer (real part, then imaginary part), a load state, the bit-serial
// square root, a state that sees it finish and the output register. A
// subcarrier with a bad digit skips the arithmetic and goes straight to the
// output state.
// One kept subcarrier is in work at a time; in_stall stays high while an
// item is in work. The output register lets the next item be accepted
// while a result waits; if out_stall holds, the finished result waits in the
// sequencer until the register is free.
// Reset clears the counters and the output valid flag, and restores keep_mask to
// its default of subcarriers 1-28 and 36-63.
module csi_subcarrier_magnitude
	import csm_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [CHAR_W-1:0] hex_chars,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [MAG_W-1:0]  magnitude,
	output logic [IDX_W-1:0]  feature_index,
	output logic [IDX_W-1:0]  subcarrier_index,
	output logic              bad_digit,
	output logic              last_feature,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [MASK_W-1:0] keep_mask
);

	state_t              state_q;
	state_t              state_d;

	logic [MASK_W-1:0]   keep_mask_q;
	logic [IDX_W-1:0]    carrier_count_q;
	logic [IDX_W-1:0]    kept_count_q;

	logic [ABS_W-1:0]    are_q;
	logic [ABS_W-1:0]    aim_q;
	logic [SUM_W-1:0]    sum_q;
	logic [IDX_W-1:0]    idx_q;
	logic [IDX_W-1:0]    feat_q;
	logic                bad_q;
	logic                last_q;

	logic                out_valid_q;
	logic [MAG_W-1:0]    magnitude_q;
	logic [IDX_W-1:0]    feature_index_q;
	logic [IDX_W-1:0]    subcarrier_index_q;
	logic                bad_digit_q;
	logic                last_feature_q;

	logic                in_accept;
	logic                kept;
	logic [PART_W:0]     re_dec;
	logic [PART_W:0]     im_dec;
	logic                chars_ok;
	logic [MASK_W-1:0]   higher;
	logic [ABS_W-1:0]    mul_op;
	logic [SUM_W-1:0]    product;
	logic                out_free;
	logic                out_load;
	logic [SAT_W-1:0]    root_ext;
	logic [MAG_W-1:0]    mag_sat;

	root_req_t           root_req;
	root_rsp_t           root_rsp;

	assign in_accept = in_valid && !in_stall;
	assign kept      = keep_mask_q[carrier_count_q];
	assign re_dec    = part_decode(hex_chars[31:0]);
	assign im_dec    = part_decode(hex_chars[63:32]);
	assign chars_ok  = re_dec[PART_W] && im_dec[PART_W];

	// Kept subcarriers strictly above the current index and below CARRIERS.
	assign higher = keep_mask_q & CARRIER_MASK & ~((64'd2 << carrier_count_q) - 64'd1);

	// The one squarer serves the real part first, then the imaginary part.
	assign mul_op  = (state_q == ST_SQ_RE) ? are_q : aim_q;
	assign product = SUM_W'(mul_op) * SUM_W'(mul_op);

	assign root_req.start    = (state_q == ST_LOAD);
	assign root_req.radicand = RAD_W'(sum_q) << (2 * FRAC_BITS);

	assign root_ext = SAT_W'(root_rsp.root);
	assign mag_sat  = (root_ext > SAT_W'(MAG_MAX)) ? MAG_MAX : MAG_W'(root_rsp.root);

	assign out_free = !out_valid_q || !out_stall;

	csm_root u_root (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (root_req),
		.rsp    (root_rsp)
	);

	always_comb begin
		state_d   = state_q;
		in_stall  = 1'b1;
		cfg_ready = 1'b0;
		out_load  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_stall  = 1'b0;
				cfg_ready = 1'b1;
				if (in_valid && kept) begin
					state_d = chars_ok ? ST_SQ_RE : ST_DONE;
				end
			end
			ST_SQ_RE: begin
				state_d = ST_SQ_IM;
			end
			ST_SQ_IM: begin
				state_d = ST_LOAD;
			end
			ST_LOAD: begin
				state_d = ST_ROOT;
			end
			ST_ROOT: begin
				if (root_rsp.done) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= ST_IDLE;
			keep_mask_q     <= MASK_RESET;
			carrier_count_q <= '0;
			kept_count_q    <= '0;
			out_valid_q     <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready) begin
				keep_mask_q <= keep_mask;
			end
			if (in_accept) begin
				if (carrier_count_q == LAST_IDX) begin
					carrier_count_q <= '0;
					kept_count_q    <= '0;
				end else begin
					carrier_count_q <= carrier_count_q + 1'b1;
					if (kept) begin
						kept_count_q <= kept_count_q + 1'b1;
					end
				end
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			are_q  <= abs_part(re_dec[PART_W-1:0]);
			aim_q  <= abs_part(im_dec[PART_W-1:0]);
			idx_q  <= carrier_count_q;
			feat_q <= kept_count_q;
			bad_q  <= !chars_ok;
			last_q <= (higher == '0);
		end
		if (state_q == ST_SQ_RE) begin
			sum_q <= product;
		end else if (state_q == ST_SQ_IM) begin
			sum_q <= sum_q + product;
		end
		if (out_load) begin
			magnitude_q        <= bad_q ? '0 : mag_sat;
			feature_index_q    <= feat_q;
			subcarrier_index_q <= idx_q;
			bad_digit_q        <= bad_q;
			last_feature_q     <= last_q;
		end
	end

	assign out_valid        = out_valid_q;
	assign magnitude        = magnitude_q;
	assign feature_index    = feature_index_q;
	assign subcarrier_index = subcarrier_index_q;
	assign bad_digit        = bad_digit_q;
	assign last_feature     = last_feature_q;

endmodule

/* design/csm_root.sv */
// Restoring integer square root, one result bit per cycle.
module csm_root
	import csm_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  root_req_t req,
	output root_rsp_t rsp
);

	logic [RAD_W-1:0]    rad_q;
	logic [ROOT_W+1:0]   rem_q;
	logic [ROOT_W-1:0]   root_q;
	logic [STEP_W-1:0]   cnt_q;
	logic                done_q;

	logic [ROOT_W+1:0]   shifted;
	logic [ROOT_W+1:0]   trial;
	logic                fits;

	// Bring down the next two radicand bits and try appending a one to the root.
	assign shifted = {rem_q[ROOT_W-1:0], rad_q[RAD_W-1 -: 2]};
	assign trial   = {root_q, 2'b01};
	assign fits    = shifted >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				cnt_q <= STEP_W'(ROOT_W);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == STEP_W'(1)) begin
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rad_q  <= req.radicand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (cnt_q != '0) begin
			rad_q <= rad_q << 2;
			if (fits) begin
				rem_q  <= shifted - trial;
				root_q <= {root_q[ROOT_W-2:0], 1'b1};
			end else begin
				rem_q  <= shifted;
				root_q <= {root_q[ROOT_W-2:0], 1'b0};
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.root = root_q;

endmodule
